>>> rtl/core/chi_pkg.sv
// Shared constants and types for the cubic Hermite interpolator.
package chi_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int K_BITS = 16;
    localparam int H_BITS = 30;
    localparam int DIV_CELLS = K_BITS;
    localparam int H_SHIFT = 3 * K_BITS - H_BITS;

    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic [31:0]        dur;
    } chi_item_t;

    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
    } chi_basis_t;

endpackage

>>> rtl/core/chi_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider that forms the phase.
module chi_div_cell import chi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic              in_sat,
    input  logic [31:0]       in_rem,
    input  logic [K_BITS-1:0] in_quot,
    input  chi_item_t         in_item,
    output logic              out_valid,
    output logic              out_sat,
    output logic [31:0]       out_rem,
    output logic [K_BITS-1:0] out_quot,
    output chi_item_t         out_item
);

    logic              valid_reg;
    logic              sat_reg;
    logic [31:0]       rem_reg;
    logic [K_BITS-1:0] quot_reg;
    chi_item_t         item_reg;

    logic [32:0]       rem2;
    logic              take;
    logic [31:0]       rem_next;
    logic [K_BITS-1:0] quot_next;

    always_comb begin
        rem2 = {in_rem, 1'b0};
        take = rem2 >= {1'b0, in_item.dur};
        if (take) begin
            rem_next = 32'(rem2 - {1'b0, in_item.dur});
        end else begin
            rem_next = rem2[31:0];
        end
        quot_next = {in_quot[K_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sat_reg  <= in_sat;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_sat   = sat_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;
    assign out_item  = item_reg;

`ifndef NO_ASSERTIONS
    // The partial remainder of a live division always stays below the divisor.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !sat_reg) |-> (rem_reg < item_reg.dur))
        else $error("division remainder not below duration");

    // A held pipeline keeps its occupancy.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(valid_reg))
        else $error("cell valid changed while held");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !valid_reg)
        else $error("cell not empty after reset");
`endif

endmodule

>>> rtl/core/chi_basis.sv
// Three-stage pipeline forming the rounded Hermite basis values from the phase.
module chi_basis import chi_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [K_BITS:0] in_k,
    input  chi_item_t     in_item,
    output logic          out_valid,
    output chi_basis_t    out_basis,
    output chi_item_t     out_item
);

    logic [2:0]            valid_reg;
    chi_item_t             item1_reg, item2_reg, item3_reg;
    logic [K_BITS:0]       k1a_reg, k1b_reg;
    logic [2*K_BITS+1:0]   k2a_reg, k2b_reg;
    logic [3*K_BITS+2:0]   k3_reg;
    chi_basis_t            basis_reg;

    logic signed [51:0] k1s, k2s, k3s;
    logic signed [51:0] h01, h10, h11;
    logic signed [51:0] rnd;
    logic signed [51:0] h01r, h10r, h11r;
    chi_basis_t         basis_next;

    always_comb begin
        k1s  = signed'(52'(k1b_reg));
        k2s  = signed'(52'(k2b_reg));
        k3s  = signed'(52'(k3_reg));
        h01  = -(k3s <<< 1) + 52'sd3 * (k2s <<< K_BITS);
        h10  = k3s - ((k2s <<< K_BITS) <<< 1) + (k1s <<< (2 * K_BITS));
        h11  = k3s - (k2s <<< K_BITS);
        rnd  = 52'sd1 <<< (H_SHIFT - 1);
        h01r = (h01 + rnd) >>> H_SHIFT;
        h10r = (h10 + rnd) >>> H_SHIFT;
        h11r = (h11 + rnd) >>> H_SHIFT;
        basis_next.h01 = h01r[31:0];
        basis_next.h10 = h10r[31:0];
        basis_next.h11 = h11r[31:0];
        basis_next.h00 = (32'sd1 <<< H_BITS) - h01r[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k1a_reg   <= in_k;
            k2a_reg   <= (2*K_BITS+2)'(in_k * in_k);
            item1_reg <= in_item;
            k1b_reg   <= k1a_reg;
            k2b_reg   <= k2a_reg;
            k3_reg    <= (3*K_BITS+3)'(k2a_reg * k1a_reg);
            item2_reg <= item1_reg;
            basis_reg <= basis_next;
            item3_reg <= item2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_basis = basis_reg;
    assign out_item  = item3_reg;

endmodule

>>> rtl/core/chi_blend.sv
// Four-stage pipeline weighting positions and velocities, with the saturating output register.
module chi_blend import chi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  chi_basis_t         in_basis,
    input  chi_item_t          in_item,
    output logic               out_valid,
    output logic signed [31:0] out_position
);

    logic [3:0]         valid_reg;
    logic signed [63:0] pa_reg, pb_reg, va_reg, vb_reg;
    logic [31:0]        dur1_reg, dur2_reg;
    logic signed [32:0] pos2_reg, w_reg, pos3_reg;
    logic signed [65:0] wd_reg;
    logic signed [31:0] position_reg;

    logic signed [64:0] psum, vsum;
    logic signed [64:0] prnd, wrnd;
    logic signed [65:0] vel;
    logic signed [65:0] total;
    logic signed [31:0] position_next;

    always_comb begin
        psum = 65'(pa_reg) + 65'(pb_reg);
        vsum = 65'(va_reg) + 65'(vb_reg);
        prnd = (psum + (65'sd1 <<< (H_BITS - 1))) >>> H_BITS;
        wrnd = (vsum + (65'sd1 <<< (H_BITS - 1))) >>> H_BITS;
        vel  = (wd_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        total = vel + 66'(pos3_reg);
        if (total > 66'sh7FFFFFFF) begin
            position_next = 32'sh7FFFFFFF;
        end else if (total < -66'sh80000000) begin
            position_next = 32'sh80000000;
        end else begin
            position_next = total[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pa_reg       <= in_item.p0 * in_basis.h00;
            pb_reg       <= in_item.p1 * in_basis.h01;
            va_reg       <= in_item.v0 * in_basis.h10;
            vb_reg       <= in_item.v1 * in_basis.h11;
            dur1_reg     <= in_item.dur;
            pos2_reg     <= prnd[32:0];
            w_reg        <= wrnd[32:0];
            dur2_reg     <= dur1_reg;
            pos3_reg     <= pos2_reg;
            wd_reg       <= 66'(w_reg) * signed'(66'(dur2_reg));
            position_reg <= position_next;
        end
    end

    assign out_valid    = valid_reg[3];
    assign out_position = position_reg;

endmodule

>>> rtl/core/cubic_hermite_interpolator.sv
// Top level of the cubic Hermite interpolator: divider cell chain, basis and blend pipelines.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | positions, velocities, elapsed time, duration
//  m_      | out       | m_valid / m_ready  | position
//
// One item per cycle while m_ready keeps the pipeline moving; each result passes through
// 16 divider cells, 3 basis stages and 4 blend stages including the output register.
// The whole pipeline advances together and holds while a result waits on m_ready.
// Reset (aresetn low, synchronous) empties every stage; no state carries across items.
module cubic_hermite_interpolator import chi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_start_position,
    input  logic signed [31:0] s_end_position,
    input  logic signed [31:0] s_start_velocity,
    input  logic signed [31:0] s_end_velocity,
    input  logic [31:0]        s_elapsed_time,
    input  logic [31:0]        s_duration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_position
);

    logic ce;

    logic              c_valid [DIV_CELLS+1];
    logic              c_sat   [DIV_CELLS+1];
    logic [31:0]       c_rem   [DIV_CELLS+1];
    logic [K_BITS-1:0] c_quot  [DIV_CELLS+1];
    chi_item_t         c_item  [DIV_CELLS+1];

    logic [K_BITS:0]   k;
    logic              b_valid;
    chi_basis_t        b_basis;
    chi_item_t         b_item;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // Zero durations and finished segments (elapsed time at or past the duration) clamp to a phase of one.
    always_comb begin
        c_valid[0]     = s_valid;
        c_sat[0]       = (s_duration == '0) || (s_elapsed_time >= s_duration);
        c_rem[0]       = s_elapsed_time;
        c_quot[0]      = '0;
        c_item[0].p0   = s_start_position;
        c_item[0].p1   = s_end_position;
        c_item[0].v0   = s_start_velocity;
        c_item[0].v1   = s_end_velocity;
        c_item[0].dur  = s_duration;
    end

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
        chi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (c_valid[i]),
            .in_sat    (c_sat[i]),
            .in_rem    (c_rem[i]),
            .in_quot   (c_quot[i]),
            .in_item   (c_item[i]),
            .out_valid (c_valid[i+1]),
            .out_sat   (c_sat[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_quot  (c_quot[i+1]),
            .out_item  (c_item[i+1])
        );
    end

    assign k = c_sat[DIV_CELLS] ? {1'b1, {K_BITS{1'b0}}} : {1'b0, c_quot[DIV_CELLS]};

    chi_basis u_basis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (c_valid[DIV_CELLS]),
        .in_k      (k),
        .in_item   (c_item[DIV_CELLS]),
        .out_valid (b_valid),
        .out_basis (b_basis),
        .out_item  (b_item)
    );

    chi_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ce           (ce),
        .in_valid     (b_valid),
        .in_basis     (b_basis),
        .in_item      (b_item),
        .out_valid    (m_valid),
        .out_position (m_position)
    );

endmodule
